@@ rtl/aes128_cfb_block_encryptor_assert.svh @@
// Assertion macros for the AES-128 CFB block encryptor.
`ifndef AES128_CFB_BLOCK_ENCRYPTOR_ASSERT_SVH
`define AES128_CFB_BLOCK_ENCRYPTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define ACBE_ASSERT_IMPL(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ACBE_ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define ACBE_ASSERT_IMPL(label, a, c, msg)
`define ACBE_ASSERT_NEXT(label, a, c, msg)
`endif
`endif

@@ rtl/acbe_pkg.sv @@
// ----------------------------------------------------------------------------
// acbe_pkg
// Shared types, constants and AES byte functions.
// ----------------------------------------------------------------------------
package acbe_pkg;
  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_IV0  = 3'd4;
  localparam logic [127:0] KEY_RESET = {32'd505821977, 32'd3435495009,
                                        32'd1894940671, 32'd941348112};
  localparam logic [127:0] IV_RESET  = {32'd13001282, 32'd491897523,
                                        32'd1810756870, 32'd2564508617};
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  typedef struct packed {
    logic [31:0] block_w3;
    logic [31:0] block_w2;
    logic [31:0] block_w1;
    logic [31:0] block_w0;
    logic [4:0]  byte_count;
    logic        reload_iv;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_w3;
    logic [31:0] out_w2;
    logic [31:0] out_w1;
    logic [31:0] out_w0;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // Control between the top level and the round unit.
  typedef struct packed {
    logic       first;
    logic       last;
    logic [3:0] round;
  } rnd_ctrl_t;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    case (r)
      4'd1: rcon = 8'h01;
      4'd2: rcon = 8'h02;
      4'd3: rcon = 8'h04;
      4'd4: rcon = 8'h08;
      4'd5: rcon = 8'h10;
      4'd6: rcon = 8'h20;
      4'd7: rcon = 8'h40;
      4'd8: rcon = 8'h80;
      4'd9: rcon = 8'h1B;
      4'd10: rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction
endpackage

@@ rtl/acbe_if.sv @@
// ----------------------------------------------------------------------------
// acbe_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface acbe_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/acbe_round.sv @@
// ----------------------------------------------------------------------------
// acbe_round
// One AES round plus the matching key schedule step, used once per cycle.
// ----------------------------------------------------------------------------
module acbe_round (
  input  acbe_pkg::rnd_ctrl_t ctrl,
  input  logic [127:0]        state_in,
  input  logic [127:0]        key_in,
  output logic [127:0]        state_out,
  output logic [127:0]        key_out
);
  import acbe_pkg::*;

  logic [127:0] ss;
  logic [127:0] mx;
  logic [127:0] nk;
  logic [31:0]  t;

  // Round key for this round derived from the previous one.
  always_comb begin
    t = sub_word({key_in[103:96], key_in[127:104]}) ^ {24'd0, rcon(ctrl.round)};
    nk[31:0]   = key_in[31:0] ^ t;
    nk[63:32]  = key_in[63:32] ^ nk[31:0];
    nk[95:64]  = key_in[95:64] ^ nk[63:32];
    nk[127:96] = key_in[127:96] ^ nk[95:64];
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[(c*4+r)*8 +: 8] = SBOX[state_in[((((c+r)&3)*4)+r)*8 +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3;
      a0 = ss[(c*4)*8 +: 8];
      a1 = ss[(c*4+1)*8 +: 8];
      a2 = ss[(c*4+2)*8 +: 8];
      a3 = ss[(c*4+3)*8 +: 8];
      mx[(c*4)*8 +: 8]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      mx[(c*4+1)*8 +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      mx[(c*4+2)*8 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      mx[(c*4+3)*8 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
  end

  always_comb begin
    if (ctrl.first) begin
      state_out = state_in ^ key_in;
      key_out   = key_in;
    end else begin
      state_out = (ctrl.last ? ss : mx) ^ nk;
      key_out   = nk;
    end
  end
endmodule

@@ rtl/aes128_cfb_block_encryptor.sv @@
// ----------------------------------------------------------------------------
// aes128_cfb_block_encryptor
// AES-128 block encryptor in CFB-128 feedback mode.
// ----------------------------------------------------------------------------
// Usage:
// The in_ channel takes one word: a 16-byte block, a byte count and a
// reload flag. The out_ channel returns one word per block, bytes at or
// beyond the count set to zero. The cfg_ channel writes the key words
// (index 0..3) and IV words (index 4..7); an IV write also loads the
// feedback. Writes are meant to arrive only while no block is in flight.
// A block passes through the shared round unit for the initial key add
// and ten rounds, with the round key computed on the fly, and the result
// is then formed in the done state. A count of zero leaves the run state
// after the first pass and gives a zero result. A new block is taken only
// once the previous result has moved into the output register.
// The result waits in an output register, so the next block can be
// ciphered while the receiver stalls; a block that finishes while the
// previous result still waits is held until that result has left.
// Reset loads the stock key and IV, returns to idle and clears out_valid.
// ----------------------------------------------------------------------------
`include "aes128_cfb_block_encryptor_assert.svh"
module aes128_cfb_block_encryptor (
  input logic clk,
  input logic rst_n,
  acbe_if.sink   in_ch,
  acbe_if.source out_ch,
  acbe_if.sink   cfg_ch
);
  import acbe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [3:0]   round_r;
  logic [127:0] key_r, iv_r, fb_r, st_r, rk_r;
  in_item_t     item_r;
  out_item_t    res_r;
  logic         out_valid_r;
  rnd_ctrl_t    ctrl;
  logic [127:0] st_out, rk_out, blk, pad, full, masked;
  logic         in_fire, cfg_fire, out_fire, done_go;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  // The finished block may move into the output register once it is empty or its result is being taken.
  assign done_go  = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign ctrl = '{first: (round_r == 4'd0), last: (round_r == 4'd10), round: round_r};

  acbe_round u_round (
    .ctrl(ctrl), .state_in(st_r), .key_in(rk_r),
    .state_out(st_out), .key_out(rk_out)
  );

  assign blk = {item_r.block_w3, item_r.block_w2, item_r.block_w1, item_r.block_w0};

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pad[i*8 +: 8] = (5'(i) < item_r.byte_count) ? blk[i*8 +: 8] : 8'h00;
    end
  end
  assign full = pad ^ st_r;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      masked[i*8 +: 8] = (5'(i) < item_r.byte_count) ? full[i*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_RUN;
      ST_RUN: begin
        if (item_r.byte_count == 5'd0 || round_r == 4'd10) state_nxt = ST_DONE;
      end
      ST_DONE: if (done_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= 4'd0;
      out_valid_r <= 1'b0;
      key_r       <= KEY_RESET;
      iv_r        <= IV_RESET;
      fb_r        <= IV_RESET;
    end else begin
      state_r <= state_nxt;
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_fire) begin
        if (cfg_ch.data.index < CFG_IV0) begin
          key_r[cfg_ch.data.index[1:0]*32 +: 32] <= cfg_ch.data.data;
        end else begin
          iv_r[cfg_ch.data.index[1:0]*32 +: 32] <= cfg_ch.data.data;
          fb_r[cfg_ch.data.index[1:0]*32 +: 32] <= cfg_ch.data.data;
        end
      end
      case (state_r)
        ST_IDLE: begin
          round_r <= 4'd0;
          if (in_fire) begin
            item_r <= in_ch.data;
            st_r   <= fb_r;
            rk_r   <= key_r;
          end
        end
        ST_RUN: begin
          st_r    <= st_out;
          rk_r    <= rk_out;
          round_r <= round_r + 4'd1;
        end
        ST_DONE: begin
          round_r <= 4'd0;
          if (done_go) begin
            if (item_r.byte_count == 5'd0) begin
              res_r <= '0;
            end else begin
              res_r <= masked;
              fb_r  <= full;
            end
            if (item_r.reload_iv) fb_r <= iv_r;
          end
        end
        default: ;
      endcase
    end
  end

  // The count field is five bits, so saturation above sixteen follows from
  // the compare against each byte position.
  `ACBE_ASSERT_IMPL(a_ready_idle, in_ch.ready, round_r == 4'd0, "ready outside idle")
  `ACBE_ASSERT_NEXT(a_run_count, state_r == ST_RUN && round_r != 4'd10 &&
    item_r.byte_count != 5'd0, state_r == ST_RUN, "round sequence cut short")
  `ACBE_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(res_r), "result dropped while stalled")
endmodule
